[sv/bc_pkg.sv]
// Shared types, constants and helper functions for the barometric compensation block.
// No dependencies; every other file imports this package.
package bc_pkg;

  // Oversampling setting and the shift it implies
  localparam int         OSS      = 0;
  localparam logic [1:0] OSS_SH   = 2'(OSS);

  // Divider width (one quotient bit per stage)
  localparam int DIV_W = 32;

  // Scheme constants
  localparam logic [31:0] C_4000    = 32'd4000;
  localparam logic [31:0] C_3038    = 32'd3038;
  localparam logic [31:0] C_M7357   = 32'hFFFF_E343;
  localparam logic [31:0] C_3791    = 32'd3791;
  localparam logic [31:0] C_P_SCALE = 32'(50000 >> OSS);
  localparam logic [31:0] C_HALF    = 32'h8000_0000;
  localparam logic [31:0] C_32768   = 32'd32768;

  // Register indexes on the configuration port
  typedef enum logic [3:0] {
    REG_AC1    = 4'd0,
    REG_AC2    = 4'd1,
    REG_AC3    = 4'd2,
    REG_AC4    = 4'd3,
    REG_AC5    = 4'd4,
    REG_AC6    = 4'd5,
    REG_B_PAIR = 4'd6,
    REG_M_PAIR = 4'd7
  } reg_idx_t;

  // Calibration set as seen by the datapath
  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
  } coef_t;

  // Sideband that rides along a divider
  typedef struct packed {
    logic        fault;
    logic        flag;
    logic [18:0] up;
    logic [31:0] word;
  } side_t;

  // Sign-extend a 16-bit coefficient to a 32-bit word
  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Arithmetic right shift of a 32-bit word
  function automatic logic [31:0] asr(logic [31:0] v, logic [4:0] n);
    return $signed(v) >>> n;
  endfunction

endpackage

[sv/bc_div.sv]
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bc_pkg (DIV_W, side_t).
module bc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [31:0]     in_a,
  input  logic [31:0]     in_b,
  input  bc_pkg::side_t   in_side,
  output logic            out_v,
  output logic [31:0]     out_q,
  output bc_pkg::side_t   out_side
);
  import bc_pkg::*;

  logic        v_r    [0:DIV_W-1];
  logic [31:0] rem_r  [0:DIV_W-1];
  logic [31:0] num_r  [0:DIV_W-1];
  logic [31:0] den_r  [0:DIV_W-1];
  side_t       side_r [0:DIV_W-1];

  for (genvar i = 0; i < DIV_W; i++) begin : g_stage
    logic        src_v;
    logic [31:0] src_rem;
    logic [31:0] src_num;
    logic [31:0] src_den;
    side_t       src_side;
    logic [32:0] trial;
    logic        qbit;
    logic [31:0] rem_nxt;

    // stage source: the inputs for the first stage, the previous stage otherwise
    if (i == 0) begin : g_first
      assign src_v    = in_v;
      assign src_rem  = '0;
      assign src_num  = in_a;
      assign src_den  = in_b;
      assign src_side = in_side;
    end else begin : g_next
      assign src_v    = v_r[i-1];
      assign src_rem  = rem_r[i-1];
      assign src_num  = num_r[i-1];
      assign src_den  = den_r[i-1];
      assign src_side = side_r[i-1];
    end

    // shift in one numerator bit, subtract when it fits
    always_comb begin
      trial = {src_rem, src_num[31]};
      qbit  = (trial >= {1'b0, src_den});
      if (qbit) begin
        rem_nxt = 32'(trial - {1'b0, src_den});
      end else begin
        rem_nxt = trial[31:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        num_r[i]  <= {src_num[30:0], qbit};
        den_r[i]  <= src_den;
        side_r[i] <= src_side;
      end
    end
  end

  assign out_v    = v_r[DIV_W-1];
  assign out_q    = num_r[DIV_W-1];
  assign out_side = side_r[DIV_W-1];

endmodule

[sv/bc_front.sv]
// Temperature front end: raw temperature scaling and setup of the first division.
// Depends on bc_pkg (coef_t, side_t, sx16, asr).
module bc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  bc_pkg::coef_t   coef,
  input  logic            in_v,
  input  logic [15:0]     in_ut,
  input  logic [18:0]     in_up,
  output logic            out_v,
  output logic [31:0]     out_a,
  output logic [31:0]     out_b,
  output bc_pkg::side_t   out_side
);
  import bc_pkg::*;

  logic        f1_v_r, f2_v_r, f3_v_r;
  logic [31:0] f1_d_r, f2_x1_r;
  logic [18:0] f1_up_r, f2_up_r;
  logic [31:0] f3_a_r, f3_b_r;
  side_t       f3_side_r;

  logic [31:0] x1_nxt, den_nxt, num_nxt;

  always_comb begin
    x1_nxt  = asr(32'(f1_d_r * {16'b0, coef.ac5}), 5'd15);
    den_nxt = 32'(f2_x1_r + sx16(coef.md));
    num_nxt = sx16(coef.mc) << 11;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_v;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  // ut - ac6, x1, then magnitudes and sign for the division
  always_ff @(posedge clk) begin
    if (en) begin
      f1_d_r          <= 32'({16'b0, in_ut} - {16'b0, coef.ac6});
      f1_up_r         <= in_up;
      f2_x1_r         <= x1_nxt;
      f2_up_r         <= f1_up_r;
      f3_a_r          <= num_nxt[31] ? 32'(-num_nxt) : num_nxt;
      f3_b_r          <= den_nxt[31] ? 32'(-den_nxt) : den_nxt;
      f3_side_r.fault <= (den_nxt == '0);
      f3_side_r.flag  <= num_nxt[31] ^ den_nxt[31];
      f3_side_r.up    <= f2_up_r;
      f3_side_r.word  <= f2_x1_r;
    end
  end

  assign out_v    = f3_v_r;
  assign out_a    = f3_a_r;
  assign out_b    = f3_b_r;
  assign out_side = f3_side_r;

endmodule

[sv/bc_mid.sv]
// Middle section: b5, temperature, the b3/b4 chain and setup of the pressure division.
// Depends on bc_pkg (coef_t, side_t, constants, sx16, asr).
module bc_mid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  bc_pkg::coef_t   coef,
  input  logic            in_v,
  input  logic [31:0]     in_q,
  input  bc_pkg::side_t   in_side,
  output logic            out_v,
  output logic [31:0]     out_a,
  output logic [31:0]     out_b,
  output bc_pkg::side_t   out_side
);
  import bc_pkg::*;

  logic [7:0]  v_r;
  logic        flt_r [1:7];
  logic [18:0] up_r  [1:5];
  logic [12:0] ts_r  [3:7];

  logic [31:0] m1_b5_r;
  logic [31:0] m2_tv_r, m2_b6_r;
  logic [31:0] m3_sq_r, m3_t2_r, m3_t3_r;
  logic [31:0] m4_x1_r, m4_x2_r, m4_t2_r, m4_t3_r;
  logic [31:0] m5_b3_r, m5_s_r;
  logic [31:0] m6_b4_r, m6_upb_r;
  logic [31:0] m7_b7_r, m7_b4_r;
  logic [31:0] m8_a_r, m8_b_r;
  side_t       m8_side_r;

  logic [31:0] x2_nxt, tv_nxt, x3_nxt, b3_nxt, s_nxt, b4_nxt;
  logic [12:0] ts_nxt;
  logic        low_half;

  always_comb begin
    x2_nxt = in_side.flag ? 32'(-in_q) : in_q;
    tv_nxt = asr(32'(m1_b5_r + 32'd8), 5'd4);
    if ($signed(m2_tv_r) < -32'sd4096) begin
      ts_nxt = 13'h1000;
    end else if ($signed(m2_tv_r) > 32'sd4095) begin
      ts_nxt = 13'h0FFF;
    end else begin
      ts_nxt = m2_tv_r[12:0];
    end
    x3_nxt   = 32'(m4_x1_r + m4_t2_r);
    b3_nxt   = asr(32'((32'((sx16(coef.ac1) << 2) + x3_nxt) << OSS_SH) + 32'd2), 5'd2);
    s_nxt    = 32'(asr(32'(m4_t3_r + m4_x2_r + 32'd2), 5'd2) + C_32768);
    b4_nxt   = 32'({16'b0, coef.ac4} * m5_s_r) >> 15;
    low_half = (m7_b7_r < C_HALF);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:0], in_v};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // b5
      m1_b5_r  <= 32'(in_side.word + x2_nxt);
      flt_r[1] <= in_side.fault;
      up_r[1]  <= in_side.up;
      // temperature word and b6
      m2_tv_r  <= tv_nxt;
      m2_b6_r  <= 32'(m1_b5_r - C_4000);
      flt_r[2] <= flt_r[1];
      up_r[2]  <= up_r[1];
      // square of b6 and the b6 coefficient terms
      m3_sq_r  <= asr(32'(m2_b6_r * m2_b6_r), 5'd12);
      m3_t2_r  <= asr(32'(sx16(coef.ac2) * m2_b6_r), 5'd11);
      m3_t3_r  <= asr(32'(sx16(coef.ac3) * m2_b6_r), 5'd13);
      ts_r[3]  <= ts_nxt;
      flt_r[3] <= flt_r[2];
      up_r[3]  <= up_r[2];
      // b2 and b1 terms
      m4_x1_r  <= asr(32'(sx16(coef.b2) * m3_sq_r), 5'd11);
      m4_x2_r  <= asr(32'(sx16(coef.b1) * m3_sq_r), 5'd16);
      m4_t2_r  <= m3_t2_r;
      m4_t3_r  <= m3_t3_r;
      ts_r[4]  <= ts_r[3];
      flt_r[4] <= flt_r[3];
      up_r[4]  <= up_r[3];
      // b3 and scale sum
      m5_b3_r  <= b3_nxt;
      m5_s_r   <= s_nxt;
      ts_r[5]  <= ts_r[4];
      flt_r[5] <= flt_r[4];
      up_r[5]  <= up_r[4];
      // b4 and up - b3
      m6_b4_r  <= b4_nxt;
      m6_upb_r <= 32'({13'b0, up_r[5]} - m5_b3_r);
      ts_r[6]  <= ts_r[5];
      flt_r[6] <= flt_r[5];
      // b7
      m7_b7_r  <= 32'(m6_upb_r * C_P_SCALE);
      m7_b4_r  <= m6_b4_r;
      ts_r[7]  <= ts_r[6];
      flt_r[7] <= flt_r[6] | (m6_b4_r == '0);
      // division setup: double before or after depending on b7
      m8_a_r          <= low_half ? {m7_b7_r[30:0], 1'b0} : m7_b7_r;
      m8_b_r          <= m7_b4_r;
      m8_side_r.fault <= flt_r[7];
      m8_side_r.flag  <= !low_half;
      m8_side_r.up    <= '0;
      m8_side_r.word  <= {19'b0, ts_r[7]};
    end
  end

  assign out_v    = v_r[7];
  assign out_a    = m8_a_r;
  assign out_b    = m8_b_r;
  assign out_side = m8_side_r;

endmodule

[sv/bc_back.sv]
// Back end: pressure correction polynomial, saturation and the output register.
// Depends on bc_pkg (side_t, constants, asr).
module bc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  logic [31:0]        in_q,
  input  bc_pkg::side_t      in_side,
  output logic               out_v,
  output logic signed [12:0] out_temp,
  output logic [17:0]        out_press,
  output logic               out_fault
);
  import bc_pkg::*;

  logic        k1_v_r, k2_v_r, k3_v_r, k4_v_r;
  logic [31:0] k1_p_r, k2_p_r, k3_p_r;
  logic [31:0] k2_sq_r, k2_m2_r, k3_x1_r, k3_m2_r;
  logic [12:0] ts_r  [1:3];
  logic        flt_r [1:3];
  logic signed [12:0] k4_t_r;
  logic [17:0] k4_p_r;
  logic        k4_f_r;

  logic [31:0] a8_nxt, pv_nxt;
  logic [17:0] ps_nxt;

  always_comb begin
    a8_nxt = asr(k1_p_r, 5'd8);
    pv_nxt = 32'(k3_p_r + asr(32'(k3_x1_r + k3_m2_r + C_3791), 5'd4));
    if (pv_nxt[31]) begin
      ps_nxt = '0;
    end else if (pv_nxt > 32'd262143) begin
      ps_nxt = 18'h3FFFF;
    end else begin
      ps_nxt = pv_nxt[17:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_v_r <= 1'b0;
      k2_v_r <= 1'b0;
      k3_v_r <= 1'b0;
      k4_v_r <= 1'b0;
    end else if (en) begin
      k1_v_r <= in_v;
      k2_v_r <= k1_v_r;
      k3_v_r <= k2_v_r;
      k4_v_r <= k3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // p
      k1_p_r   <= in_side.flag ? {in_q[30:0], 1'b0} : in_q;
      ts_r[1]  <= in_side.word[12:0];
      flt_r[1] <= in_side.fault;
      // (p>>8)^2 and linear term
      k2_sq_r  <= 32'(a8_nxt * a8_nxt);
      k2_m2_r  <= asr(32'(C_M7357 * k1_p_r), 5'd16);
      k2_p_r   <= k1_p_r;
      ts_r[2]  <= ts_r[1];
      flt_r[2] <= flt_r[1];
      // quadratic term
      k3_x1_r  <= asr(32'(k2_sq_r * C_3038), 5'd16);
      k3_m2_r  <= k2_m2_r;
      k3_p_r   <= k2_p_r;
      ts_r[3]  <= ts_r[2];
      flt_r[3] <= flt_r[2];
      // output beat, zeroed on a divide fault
      k4_f_r   <= flt_r[3];
      k4_t_r   <= flt_r[3] ? '0 : $signed(ts_r[3]);
      k4_p_r   <= flt_r[3] ? '0 : ps_nxt;
    end
  end

  assign out_v     = k4_v_r;
  assign out_temp  = k4_t_r;
  assign out_press = k4_p_r;
  assign out_fault = k4_f_r;

endmodule

[sv/barometric_compensation.sv]
// Barometric compensation top level. Registered stages from input beat to result beat:
// 3 front, 32 per divider stage chain twice, 8 middle, 4 back; the two 32-stage
// pipelined dividers make up most of them. Throughput one beat per cycle; the whole pipeline
// holds while a result beat is stalled. Synchronous active-low reset clears all valid
// bits and loads the calibration registers with their factory defaults.
// Depends on bc_pkg, bc_front, bc_div, bc_mid, bc_back.
module barometric_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_raw_temperature,
  input  logic [18:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [12:0] out_temperature_tenths,
  output logic [17:0]        out_pressure_pa,
  output logic               out_divide_fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import bc_pkg::*;

  logic [15:0] ac1_r, ac2_r, ac3_r, ac4_r, ac5_r, ac6_r;
  logic [31:0] b_pair_r, m_pair_r;
  coef_t       coef;
  logic        en;

  logic        fr_v, d1_v, md_v, d2_v;
  logic [31:0] fr_a, fr_b, d1_q, md_a, md_b, d2_q;
  side_t       fr_side, d1_side, md_side, d2_side;

  // pipeline advances unless the result beat is held
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // calibration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac1_r    <= 16'd408;
      ac2_r    <= 16'hFFB8;
      ac3_r    <= 16'd51153;
      ac4_r    <= 16'd32741;
      ac5_r    <= 16'd32757;
      ac6_r    <= 16'd23153;
      b_pair_r <= 32'd405667844;
      m_pair_r <= 32'd3724086068;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_AC1:    ac1_r    <= cfg_data[15:0];
        REG_AC2:    ac2_r    <= cfg_data[15:0];
        REG_AC3:    ac3_r    <= cfg_data[15:0];
        REG_AC4:    ac4_r    <= cfg_data[15:0];
        REG_AC5:    ac5_r    <= cfg_data[15:0];
        REG_AC6:    ac6_r    <= cfg_data[15:0];
        REG_B_PAIR: b_pair_r <= cfg_data;
        REG_M_PAIR: m_pair_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.ac1 = ac1_r;
    coef.ac2 = ac2_r;
    coef.ac3 = ac3_r;
    coef.ac4 = ac4_r;
    coef.ac5 = ac5_r;
    coef.ac6 = ac6_r;
    coef.b1  = b_pair_r[31:16];
    coef.b2  = b_pair_r[15:0];
    coef.mc  = m_pair_r[31:16];
    coef.md  = m_pair_r[15:0];
  end

  bc_front u_front (
    .clk, .rst_n, .en, .coef,
    .in_v(in_valid), .in_ut(in_raw_temperature), .in_up(in_raw_pressure),
    .out_v(fr_v), .out_a(fr_a), .out_b(fr_b), .out_side(fr_side)
  );

  bc_div u_div_temp (
    .clk, .rst_n, .en,
    .in_v(fr_v), .in_a(fr_a), .in_b(fr_b), .in_side(fr_side),
    .out_v(d1_v), .out_q(d1_q), .out_side(d1_side)
  );

  bc_mid u_mid (
    .clk, .rst_n, .en, .coef,
    .in_v(d1_v), .in_q(d1_q), .in_side(d1_side),
    .out_v(md_v), .out_a(md_a), .out_b(md_b), .out_side(md_side)
  );

  bc_div u_div_press (
    .clk, .rst_n, .en,
    .in_v(md_v), .in_a(md_a), .in_b(md_b), .in_side(md_side),
    .out_v(d2_v), .out_q(d2_q), .out_side(d2_side)
  );

  bc_back u_back (
    .clk, .rst_n, .en,
    .in_v(d2_v), .in_q(d2_q), .in_side(d2_side),
    .out_v(out_valid), .out_temp(out_temperature_tenths),
    .out_press(out_pressure_pa), .out_fault(out_divide_fault)
  );

  // a faulted beat carries zero results
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_fault |-> out_pressure_pa == '0 && out_temperature_tenths == '0)
    else $error("faulted result beat with nonzero fields");

  // a held result freezes the divider feeds
  a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(fr_v) && $stable(md_v) && $stable(d2_v))
    else $error("pipeline moved while result beat was held");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !fr_v && !md_v)
    else $error("valid bit survived reset");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for barometric_compensation: drives raw sensor words,
// predicts temperature and pressure with its own integer model. Depends on bc_pkg.
module tb_top;
  import bc_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [15:0]        in_raw_temperature = '0;
  logic [18:0]        in_raw_pressure = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [12:0] out_temperature_tenths;
  logic [17:0]        out_pressure_pa;
  logic               out_divide_fault;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [3:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  localparam int LATENCY = 79;

  typedef struct packed {
    logic [12:0] temp;
    logic [17:0] press;
    logic        fault;
  } reading_t;

  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
    bit          typed;
    reading_t    want;
  } stim_row_t;

  // calibration shadow
  logic [15:0] cal_ac1, cal_ac2, cal_ac3, cal_ac4, cal_ac5, cal_ac6;
  logic [31:0] cal_b, cal_m;

  reading_t    readings_due[$];
  int          errors = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          faults_seen = 0;

  barometric_compensation i_dut (.*);

  always #4 clk = ~clk;

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shr_s(logic [31:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  // truncating signed divide, min/-1 wraps
  function automatic logic [31:0] div_s(logic [31:0] a, logic [31:0] b);
    logic [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut, logic [18:0] up);
    reading_t r;
    logic [31:0] x1, x2, x3, b5, b6, b3, b4, b7, p, sq, den, tv, pv;
    logic [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0] shp;
    ac1 = sext(cal_ac1); ac2 = sext(cal_ac2); ac3 = sext(cal_ac3);
    b1 = sext(cal_b[31:16]); b2 = sext(cal_b[15:0]);
    mc = sext(cal_m[31:16]); md = sext(cal_m[15:0]);
    r = '0;
    x1 = shr_s(({16'd0, ut} - {16'd0, cal_ac6}) * {16'd0, cal_ac5}, 15);
    den = x1 + md;
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = div_s(mc << 11, den);
    b5 = x1 + x2;
    tv = shr_s(b5 + 32'd8, 4);
    b6 = b5 - C_4000;
    sq = shr_s(b6 * b6, 12);
    x1 = shr_s(b2 * sq, 11);
    x2 = shr_s(ac2 * b6, 11);
    x3 = x1 + x2;
    shp = (ac1 * 32'd4 + x3) << OSS_SH;
    b3 = shr_s(shp + 32'd2, 2);
    x1 = shr_s(ac3 * b6, 13);
    x2 = shr_s(b1 * sq, 16);
    x3 = shr_s(x1 + x2 + 32'd2, 2);
    b4 = ({16'd0, cal_ac4} * (x3 + C_32768)) >> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    b7 = ({13'd0, up} - b3) * C_P_SCALE;
    if (b7 < C_HALF) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = shr_s(p, 8) * shr_s(p, 8);
    x1 = shr_s(x1 * C_3038, 16);
    x2 = shr_s(C_M7357 * p, 16);
    pv = p + shr_s(x1 + x2 + C_3791, 4);
    if ($signed(tv) < -4096) r.temp = 13'h1000;
    else if ($signed(tv) > 4095) r.temp = 13'h0FFF;
    else r.temp = tv[12:0];
    if ($signed(pv) < 0) r.press = '0;
    else if ($signed(pv) > 262143) r.press = 18'h3FFFF;
    else r.press = pv[17:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("MISMATCH beat %0d %s: got %0d want %0d", beats_out, what, got, want);
  endtask

  task automatic cal_reset_shadow();
    cal_ac1 = 16'd408; cal_ac2 = 16'hFFB8; cal_ac3 = 16'hC7D1;
    cal_ac4 = 16'd32741; cal_ac5 = 16'd32757; cal_ac6 = 16'd23153;
    cal_b = 32'd405667844; cal_m = 32'd3724086068;
  endtask

  // one register write, then cfg_valid is dropped and the shadow copy updated
  task automatic write_cal(reg_idx_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_AC1:    cal_ac1 = val[15:0];
      REG_AC2:    cal_ac2 = val[15:0];
      REG_AC3:    cal_ac3 = val[15:0];
      REG_AC4:    cal_ac4 = val[15:0];
      REG_AC5:    cal_ac5 = val[15:0];
      REG_AC6:    cal_ac6 = val[15:0];
      REG_B_PAIR: cal_b = val;
      REG_M_PAIR: cal_m = val;
      default: ;
    endcase
  endtask

  // one input beat with random lead gap; optional typed expectation
  task automatic send_sample(logic [15:0] ut, logic [18:0] up, bit typed, reading_t want);
    reading_t pred;
    repeat ($urandom_range(0, 3)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    pred = compensate(ut, up);
    if (typed && pred != want)
      $display("note: typed row differs from prediction for ut=%0d up=%0d", ut, up);
    readings_due.push_back(typed ? want : pred);
    in_valid <= 1'b1;
    in_raw_temperature <= ut;
    in_raw_pressure <= up;
    do @(posedge clk); while (in_stall);
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_cal();
    write_cal(REG_AC1, $urandom_range(0, 1) ? 32'($urandom_range(0, 800)) : $urandom);
    write_cal(REG_AC2, $urandom_range(0, 1) ? 32'(-$urandom_range(0, 2000)) : $urandom);
    write_cal(REG_AC3, $urandom_range(0, 1) ? 32'(-$urandom_range(10000, 16000)) : $urandom);
    write_cal(REG_AC4, $urandom_range(0, 1) ? 32'($urandom_range(30000, 36000)) : $urandom);
    write_cal(REG_AC5, $urandom_range(0, 1) ? 32'($urandom_range(24000, 34000)) : $urandom);
    write_cal(REG_AC6, $urandom_range(0, 1) ? 32'($urandom_range(16000, 26000)) : $urandom);
    write_cal(REG_B_PAIR, $urandom);
    write_cal(REG_M_PAIR, $urandom_range(0, 1) ? {16'hD4BD, 16'($urandom_range(2000, 3000))}
                                               : $urandom);
  endtask

  // result side: random stall, check each beat against oldest expectation
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      beats_out++;
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = readings_due.pop_front();
        if (out_temperature_tenths !== want.temp)
          report_mismatch("temperature_tenths", out_temperature_tenths, $signed(want.temp));
        if (out_pressure_pa !== want.press)
          report_mismatch("pressure_pa", out_pressure_pa, want.press);
        if (out_divide_fault !== want.fault)
          report_mismatch("divide_fault", out_divide_fault, want.fault);
        if (want.fault) faults_seen++;
      end
    end
  end

  int stall_left = 0;
  int calm_left = 0;
  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 3) calm_left <= $urandom_range(50, 200);
      else stall_left <= $urandom_range(0, 3);
    end
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    reading_t  none;
    none = '0;
    cal_reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: none typed, all predicted by the model
    rows.push_back('{16'd27898, 19'd23843, 1'b0, none});
    rows.push_back('{16'd0, 19'd0, 1'b0, none});
    rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, none});
    rows.push_back('{16'hFFFF, 19'd0, 1'b0, none});
    rows.push_back('{16'd0, 19'h7FFFF, 1'b0, none});
    rows.push_back('{16'hAAAA, 19'h55555, 1'b0, none});
    rows.push_back('{16'h5555, 19'h2AAAA, 1'b0, none});
    rows.push_back('{16'd23153, 19'd40000, 1'b0, none});
    foreach (rows[i]) send_sample(rows[i].ut, rows[i].up, rows[i].typed, rows[i].want);
    drain();

    // temperature divisor zero: ut=ac6 gives x1=0, md=0
    write_cal(REG_M_PAIR, {16'hD4BD, 16'd0});
    row = '{16'd23153, 19'd30000, 1'b1, reading_t'{13'd0, 18'd0, 1'b1}};
    send_sample(row.ut, row.up, row.typed, row.want);
    drain();
    // pressure divisor zero: ac4 = 0
    cal_reset_shadow();
    write_cal(REG_M_PAIR, 32'd3724086068);
    write_cal(REG_AC4, 32'd0);
    send_sample(16'd27898, 19'd23843, 1'b1, reading_t'{13'd0, 18'd0, 1'b1});
    send_sample(16'd0, 19'h7FFFF, 1'b1, reading_t'{13'd0, 18'd0, 1'b1});
    drain();
    // extreme coefficients
    write_cal(REG_AC1, 32'h8000);   write_cal(REG_AC2, 32'h7FFF);
    write_cal(REG_AC3, 32'h8000);   write_cal(REG_AC4, 32'hFFFF);
    write_cal(REG_AC5, 32'hFFFF);   write_cal(REG_AC6, 32'h0);
    write_cal(REG_B_PAIR, 32'h7FFF_8000); write_cal(REG_M_PAIR, 32'h8000_7FFF);
    send_sample(16'hFFFF, 19'h7FFFF, 1'b0, none);
    send_sample(16'd0, 19'd0, 1'b0, none);
    send_sample(16'd12345, 19'd300000, 1'b0, none);
    drain();
    write_cal(REG_AC1, 32'h7FFF);   write_cal(REG_AC3, 32'h7FFF);
    write_cal(REG_AC5, 32'h0);      write_cal(REG_AC6, 32'hFFFF);
    write_cal(REG_B_PAIR, 32'h8000_7FFF); write_cal(REG_M_PAIR, 32'h7FFF_8000);
    send_sample(16'hFFFF, 19'h7FFFF, 1'b0, none);
    send_sample(16'd0, 19'd1, 1'b0, none);
    drain();

    // random phases: realistic and wild calibration sets
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        cal_reset_shadow();
        write_cal(REG_AC1, 32'd408);   write_cal(REG_AC2, 32'hFFB8);
        write_cal(REG_AC3, 32'hC7D1);  write_cal(REG_AC4, 32'd32741);
        write_cal(REG_AC5, 32'd32757); write_cal(REG_AC6, 32'd23153);
        write_cal(REG_B_PAIR, 32'd405667844); write_cal(REG_M_PAIR, 32'd3724086068);
      end else begin
        random_cal();
      end
      for (int k = 0; k < 48; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_sample(16'($urandom_range(20000, 36000)), 19'($urandom_range(15000, 45000)),
                      1'b0, none);
        else
          send_sample(16'($urandom), 19'($urandom), 1'b0, none);
      end
      drain();
    end

    $display("covered %0d input beats, %0d result beats, %0d divide faults",
             beats_in, beats_out, faults_seen);
    $display("calibration swept through reset, extreme and random sets");
    if (errors == 0 && readings_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
